@@ rtl/dtm_pkg.sv @@
// dtm_pkg: shared types and constants of the table-driven DFA matcher.
// Used by the interfaces and by every module of the block but dtm_ram.
package dtm_pkg;

    localparam int SYM_W = 8;   // text byte
    localparam int CLS_W = 6;   // symbol class field
    localparam int ST_W  = 8;   // DFA state field

    localparam logic [SYM_W-1:0] SPACE_BYTE  = 8'h20;  // ' '
    localparam logic [SYM_W-1:0] BAR_BYTE    = 8'h7C;  // '|'
    localparam logic [CLS_W-1:0] OTHER_RESET = 6'd63;

    localparam int MAP_DEPTH = 1 << SYM_W;

    // result queue
    localparam int RES_FIFO_DEPTH = 4;
    localparam int RES_PTR_W      = $clog2(RES_FIFO_DEPTH);
    localparam int RES_CNT_W      = RES_PTR_W + 1;

    typedef enum logic [1:0] {
        CMD_WR_TRANS = 2'd0,
        CMD_WR_CLASS = 2'd1,
        CMD_TEXT     = 2'd2,
        CMD_RESTART  = 2'd3
    } t_cmd;

    // item after class lookup, entering the transition stage
    typedef struct packed {
        logic             vld;
        t_cmd             cmd;
        logic [CLS_W-1:0] cls;
        logic [ST_W-1:0]  from_state;
        logic [ST_W-1:0]  to_state;
        logic             last;
    } t_s1;

    typedef struct packed {
        logic            vld;
        logic [ST_W-1:0] state;
    } t_res_push;

    typedef struct packed {
        logic busy;     // clear sweep running
        logic s2_last;  // result read in flight
    } t_step_status;

endpackage

@@ rtl/dtm_if.sv @@
// dtm_if: valid/ready channels of the DFA matcher (command, result, config).
// Depends on dtm_pkg.
interface dtm_cmd_if import dtm_pkg::*; ();
    logic             valid;
    logic             ready;
    t_cmd             command;
    logic [SYM_W-1:0] symbol_byte;
    logic [CLS_W-1:0] class_index;
    logic [ST_W-1:0]  from_state;
    logic [ST_W-1:0]  to_state;
    logic             last;

    modport source (output valid, command, symbol_byte, class_index, from_state, to_state,
                    last, input ready);
    modport sink (input valid, command, symbol_byte, class_index, from_state, to_state,
                  last, output ready);
endinterface

interface dtm_res_if import dtm_pkg::*; ();
    logic            valid;
    logic            ready;
    logic [ST_W-1:0] final_state;

    modport source (output valid, final_state, input ready);
    modport sink (input valid, final_state, output ready);
endinterface

interface dtm_cfg_if import dtm_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [CLS_W-1:0] other_class;

    modport source (output valid, other_class, input ready);
    modport sink (input valid, other_class, output ready);
endinterface

@@ rtl/dtm_ram.sv @@
// dtm_ram: generic simple dual-port RAM, one write and one registered read port.
// No dependencies.
module dtm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ rtl/dtm_class_map.sv @@
// dtm_class_map: byte-to-class map (RAM plus valid flops) and first pipeline stage.
// Depends on dtm_pkg and dtm_ram.
module dtm_class_map import dtm_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_accept,
    input  t_cmd             i_command,
    input  logic [SYM_W-1:0] i_symbol_byte,
    input  logic [CLS_W-1:0] i_class_index,
    input  logic [ST_W-1:0]  i_from_state,
    input  logic [ST_W-1:0]  i_to_state,
    input  logic             i_last,
    input  logic [CLS_W-1:0] i_other_class,
    output t_s1              o_s1
);

    logic [MAP_DEPTH-1:0] r_map_vld;
    logic                 r_s1_vld;
    t_cmd                 r_cmd;
    logic [CLS_W-1:0]     r_cls;
    logic [ST_W-1:0]      r_from_state;
    logic [ST_W-1:0]      r_to_state;
    logic                 r_last;
    logic                 r_hit;

    logic [SYM_W-1:0] lookup_byte;
    logic             map_we;
    logic [CLS_W-1:0] map_rdata;

    // space is looked up as '|'
    assign lookup_byte = (i_command == CMD_TEXT && i_symbol_byte == SPACE_BYTE) ?
                         BAR_BYTE : i_symbol_byte;
    assign map_we = i_accept && (i_command == CMD_WR_CLASS);

    dtm_ram #(
        .WIDTH (CLS_W),
        .DEPTH (MAP_DEPTH)
    ) u_map_ram (
        .i_clk   (i_clk),
        .i_we    (map_we),
        .i_waddr (i_symbol_byte),
        .i_wdata (i_class_index),
        .i_raddr (lookup_byte),
        .o_rdata (map_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_map_vld <= '0;
            r_s1_vld  <= 1'b0;
        end else begin
            r_s1_vld <= i_accept;
            if (map_we) begin
                r_map_vld[i_symbol_byte] <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_cmd        <= i_command;
            r_cls        <= i_class_index;
            r_from_state <= i_from_state;
            r_to_state   <= i_to_state;
            r_last       <= i_last;
            r_hit        <= r_map_vld[lookup_byte];
        end
    end

    always_comb begin
        o_s1.vld        = r_s1_vld;
        o_s1.cmd        = r_cmd;
        o_s1.from_state = r_from_state;
        o_s1.to_state   = r_to_state;
        o_s1.last       = r_last;
        if (r_cmd == CMD_TEXT) begin
            o_s1.cls = r_hit ? map_rdata : i_other_class;
        end else begin
            o_s1.cls = r_cls;
        end
    end

endmodule

@@ rtl/dtm_trans_step.sv @@
// dtm_trans_step: transition store, clear sweep and current-state feedback.
// Depends on dtm_pkg and dtm_ram.
module dtm_trans_step import dtm_pkg::*; #(
    parameter int MAX_STATES  = 256,
    parameter int MAX_CLASSES = 64
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  t_s1          i_s1,
    output t_res_push    o_res,
    output t_step_status o_status
);

    localparam int DEPTH  = MAX_STATES * MAX_CLASSES;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int ST_AW  = $clog2(MAX_STATES);
    localparam int CLS_AW = $clog2(MAX_CLASSES);

    logic              r_clearing;
    logic [ADDR_W-1:0] r_clr_addr;
    logic [ST_W-1:0]   r_cur_state;
    logic              r_rd_pend;
    logic              r_s2_last;

    logic [ST_AW-1:0]  st_mod  [1 << ST_W];
    logic [CLS_AW-1:0] cls_mod [1 << CLS_W];

    logic [ST_W-1:0]   ram_rdata;
    logic [ST_W-1:0]   eff_state;
    logic [ST_W-1:0]   st_sel;
    logic [ADDR_W-1:0] addr;
    logic              is_wr;
    logic              ram_we;
    logic [ADDR_W-1:0] ram_waddr;
    logic [ST_W-1:0]   ram_wdata;

    // index wrap tables, fixed at elaboration
    for (genvar g = 0; g < (1 << ST_W); g++) begin : g_st_mod
        assign st_mod[g] = ST_AW'(g % MAX_STATES);
    end
    for (genvar g = 0; g < (1 << CLS_W); g++) begin : g_cls_mod
        assign cls_mod[g] = CLS_AW'(g % MAX_CLASSES);
    end

    // state forwarded straight from the RAM after a text byte
    assign eff_state = r_rd_pend ? ram_rdata : r_cur_state;
    assign is_wr     = i_s1.vld && (i_s1.cmd == CMD_WR_TRANS);
    assign st_sel    = is_wr ? i_s1.from_state : eff_state;
    assign addr      = ADDR_W'(cls_mod[i_s1.cls]) * ADDR_W'(MAX_STATES)
                     + ADDR_W'(st_mod[st_sel]);

    assign ram_we    = r_clearing || is_wr;
    assign ram_waddr = r_clearing ? r_clr_addr : addr;
    assign ram_wdata = r_clearing ? '0 : i_s1.to_state;

    dtm_ram #(
        .WIDTH (ST_W),
        .DEPTH (DEPTH)
    ) u_trans_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (addr),
        .o_rdata (ram_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clearing  <= 1'b1;
            r_clr_addr  <= '0;
            r_cur_state <= '0;
            r_rd_pend   <= 1'b0;
            r_s2_last   <= 1'b0;
        end else begin
            if (r_clearing) begin
                r_clr_addr <= r_clr_addr + 1'b1;
                if (r_clr_addr == ADDR_W'(DEPTH - 1)) begin
                    r_clearing <= 1'b0;
                end
            end
            r_s2_last <= i_s1.vld && (i_s1.cmd == CMD_TEXT) && i_s1.last;
            priority if (i_s1.vld && i_s1.cmd == CMD_TEXT) begin
                r_rd_pend <= 1'b1;
            end else if (i_s1.vld && i_s1.cmd == CMD_RESTART) begin
                r_rd_pend   <= 1'b0;
                r_cur_state <= '0;
            end else begin
                r_rd_pend   <= 1'b0;
                r_cur_state <= eff_state;
            end
        end
    end

    assign o_res.vld        = r_s2_last;
    assign o_res.state      = ram_rdata;
    assign o_status.busy    = r_clearing;
    assign o_status.s2_last = r_s2_last;

endmodule

@@ rtl/dtm_res_fifo.sv @@
// dtm_res_fifo: small result queue between the pipeline and the result channel.
// Depends on dtm_pkg and dtm_if.
module dtm_res_fifo import dtm_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  t_res_push            i_push,
    output logic [RES_CNT_W-1:0] o_count,
    dtm_res_if.source            o_res
);

    logic [ST_W-1:0]      r_mem [RES_FIFO_DEPTH];
    logic [RES_PTR_W-1:0] r_wr_ptr;
    logic [RES_PTR_W-1:0] r_rd_ptr;
    logic [RES_CNT_W-1:0] r_count;
    logic                 pop;

    assign pop = o_res.valid && o_res.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push.vld) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            unique case ({i_push.vld, pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push.vld) begin
            r_mem[r_wr_ptr] <= i_push.state;
        end
    end

    assign o_res.valid       = (r_count != '0);
    assign o_res.final_state = r_mem[r_rd_ptr];
    assign o_count           = r_count;

endmodule

@@ rtl/dfa_table_matcher.sv @@
// dfa_table_matcher: top level of the table-driven DFA matcher.
// Depends on dtm_pkg, dtm_if, dtm_class_map, dtm_trans_step, dtm_res_fifo.
//
// A DFA run over a byte stream. Commands load transition entries (class,
// from state -> next state) and byte-to-class map entries, feed text bytes,
// or restart the DFA at state 0. A text byte ' ' is looked up as '|'; a byte
// with no map entry takes the class in the other_class register (reset 63).
// Class and state wrap modulo MAX_CLASSES and MAX_STATES when the store is
// addressed. A text byte with last set returns the state reached after it.
// Throughput is one item per clock while i_cmd.ready is high: the map read
// happens in the cycle an item is accepted, the transition read in the next,
// and the new state is forwarded from the transition RAM output straight into
// the next byte's address, so that RAM-read-to-address loop sets the clock
// rate. A result passes the class-map stage, the transition read and the result
// queue before it shows on o_res. Up to four results may be pending (queued or
// in flight); beyond that i_cmd.ready drops until o_res drains. After reset the
// transition store is swept to zero, one entry a cycle, over all MAX_STATES *
// MAX_CLASSES entries; i_cmd.ready stays low for that time while the config
// port still takes writes. Write other_class only while the block is idle.
module dfa_table_matcher import dtm_pkg::*; #(
    parameter int MAX_STATES  = 256,
    parameter int MAX_CLASSES = 64
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    dtm_cmd_if.sink   i_cmd,
    dtm_cfg_if.sink   i_cfg,
    dtm_res_if.source o_res
);

    logic [CLS_W-1:0]     r_other_class;
    logic                 cmd_accept;
    t_s1                  s1;
    t_res_push            res_push;
    t_step_status         step_st;
    logic [RES_CNT_W-1:0] fifo_count;
    logic [RES_CNT_W-1:0] pend_count;
    logic                 s1_last;

    // config register, always ready
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_other_class <= OTHER_RESET;
        end else if (i_cfg.valid) begin
            r_other_class <= i_cfg.other_class;
        end
    end

    // results still to be delivered: queued plus both pipeline stages
    assign s1_last    = s1.vld && (s1.cmd == CMD_TEXT) && s1.last;
    assign pend_count = fifo_count + RES_CNT_W'(s1_last) + RES_CNT_W'(step_st.s2_last);
    assign i_cmd.ready = !step_st.busy && (pend_count < RES_CNT_W'(RES_FIFO_DEPTH));
    assign cmd_accept  = i_cmd.valid && i_cmd.ready;

    dtm_class_map u_class_map (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_accept      (cmd_accept),
        .i_command     (i_cmd.command),
        .i_symbol_byte (i_cmd.symbol_byte),
        .i_class_index (i_cmd.class_index),
        .i_from_state  (i_cmd.from_state),
        .i_to_state    (i_cmd.to_state),
        .i_last        (i_cmd.last),
        .i_other_class (r_other_class),
        .o_s1          (s1)
    );

    dtm_trans_step #(
        .MAX_STATES  (MAX_STATES),
        .MAX_CLASSES (MAX_CLASSES)
    ) u_trans_step (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_s1     (s1),
        .o_res    (res_push),
        .o_status (step_st)
    );

    dtm_res_fifo u_res_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (res_push),
        .o_count (fifo_count),
        .o_res   (o_res)
    );

endmodule

@@ rtl/dtm_checker.sv @@
// dtm_checker: port-level assertions for dfa_table_matcher, bound to the top.
// Depends on dtm_pkg.
module dtm_checker import dtm_pkg::*; (
    input logic            i_clk,
    input logic            i_rst_n,
    input logic            i_cmd_valid,
    input logic            i_cmd_ready,
    input t_cmd            i_cmd_command,
    input logic            i_cmd_last,
    input logic            i_res_valid,
    input logic            i_res_ready,
    input logic [ST_W-1:0] i_res_state
);

    logic text_last_acc;
    assign text_last_acc = i_cmd_valid && i_cmd_ready && (i_cmd_command == CMD_TEXT)
                         && i_cmd_last;

    // store sweep starts at reset, so no item is taken right after it
    a_no_accept_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_cmd_ready)
        else $error("command ready right after reset");

    // reset empties the result queue
    a_no_result_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_res_valid)
        else $error("result valid right after reset");

    // an accepted final text byte is followed by a valid result on o_res
    a_result_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        text_last_acc |-> ##3 i_res_valid)
        else $error("no result three cycles after a final text byte");

    // a stalled result holds
    a_res_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid && !i_res_ready |=> i_res_valid && $stable(i_res_state))
        else $error("stalled result changed");

endmodule

bind dfa_table_matcher dtm_checker u_dtm_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_cmd_valid   (i_cmd.valid),
    .i_cmd_ready   (i_cmd.ready),
    .i_cmd_command (i_cmd.command),
    .i_cmd_last    (i_cmd.last),
    .i_res_valid   (o_res.valid),
    .i_res_ready   (o_res.ready),
    .i_res_state   (o_res.final_state)
);

@@ tb/sv/testbench.sv @@
// testbench: self-checking bench for dfa_table_matcher, predicting final states in SV.
// Depends on dtm_pkg, the dtm_*_if interfaces and the dfa_table_matcher RTL.
`timescale 1ns / 1ps

module testbench import dtm_pkg::*; ();

    localparam int N_STATES        = 256;
    localparam int N_CLASSES       = 64;
    localparam int PHASE_ITEMS     = 470;
    localparam int SETTLE_CYCLES   = 8;    // margin for results still in the pipeline
    localparam int RX_HOLD_CYCLES  = 300;
    localparam int PRESSURE_ITEMS  = 24;
    localparam int DIR_ROWS        = 24;
    localparam logic [SYM_W-1:0] CARET_BYTE = 8'h5E;  // '^', no special meaning

    // one command item as it crosses the handshake
    typedef struct packed {
        t_cmd             cmd;
        logic [SYM_W-1:0] sym;
        logic [CLS_W-1:0] cls;
        logic [ST_W-1:0]  from_st;
        logic [ST_W-1:0]  to_st;
        logic             last;
    } t_dfa_item;

    // directed row: chk set where the final state is typed in by hand
    typedef struct packed {
        t_dfa_item       it;
        logic            chk;
        logic [ST_W-1:0] want;
    } t_dir_row;

    logic i_clk = 1'b0;
    logic i_rst_n;

    dtm_cmd_if cmd_ch ();
    dtm_cfg_if cfg_ch ();
    dtm_res_if res_ch ();

    dfa_table_matcher i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd_ch),
        .i_cfg   (cfg_ch),
        .o_res   (res_ch)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Predictor state: transition store, byte map, DFA state, other class
    // ------------------------------------------------------------------
    logic [ST_W-1:0]  trans_mem [0:N_STATES*N_CLASSES-1];
    logic             map_vld   [0:MAP_DEPTH-1];
    logic [CLS_W-1:0] map_cls   [0:MAP_DEPTH-1];
    logic [ST_W-1:0]  dfa_state;
    logic [CLS_W-1:0] other_cls;

    logic [ST_W-1:0] final_state_q [$];   // final states still owed by the block
    int              mismatch_cnt = 0;
    int              items_sent   = 0;

    logic tx_idle_en = 1'b1;
    logic rx_idle_en = 1'b1;
    logic tx_live    = 1'b0;   // mirror of cmd valid as last driven
    logic hold_req   = 1'b0;   // asks the receiver for one long hold-off
    logic hold_done  = 1'b0;   // long hold-off already requested

    // Advance the DFA by one command; returns 1 when a final state is emitted.
    // Store address is {class, state}, so the width of each field gives the wrap.
    function automatic logic dfa_advance(input t_dfa_item it, output logic [ST_W-1:0] st_out);
        logic [SYM_W-1:0] b;
        logic [CLS_W-1:0] c;
        dfa_advance = 1'b0;
        case (it.cmd)
            CMD_WR_TRANS: trans_mem[{it.cls, it.from_st}] = it.to_st;
            CMD_WR_CLASS: begin
                map_vld[it.sym] = 1'b1;
                map_cls[it.sym] = it.cls;
            end
            CMD_TEXT: begin
                // space is looked up as bar; its own map entry is never read
                b = (it.sym == SPACE_BYTE) ? BAR_BYTE : it.sym;
                c = map_vld[b] ? map_cls[b] : other_cls;
                dfa_state = trans_mem[{c, dfa_state}];
                dfa_advance = it.last;
            end
            default: dfa_state = '0;   // restart
        endcase
        st_out = dfa_state;
    endfunction

    function automatic t_dfa_item mk_item(input t_cmd cmd, input logic [SYM_W-1:0] sym,
                                          input logic [CLS_W-1:0] cls,
                                          input logic [ST_W-1:0] from_st,
                                          input logic [ST_W-1:0] to_st, input logic last);
        mk_item = '{cmd, sym, cls, from_st, to_st, last};
    endfunction

    // Offer one item, wait for the handshake, then predict. valid stays high
    // after the handshake so items can go back to back without valid dropping.
    task automatic send_cmd(input t_dfa_item it, input logic use_typed = 1'b0,
                            input logic [ST_W-1:0] typed_st = '0);
        logic [ST_W-1:0] st;
        logic            has_res;
        if (tx_idle_en && $urandom_range(0, 99) < 8) begin
            if (tx_live) cmd_ch.valid <= 1'b0;
            tx_live = 1'b0;
            repeat ($urandom_range(1, 11)) @(posedge i_clk);
        end
        cmd_ch.valid       <= 1'b1;
        cmd_ch.command     <= it.cmd;
        cmd_ch.symbol_byte <= it.sym;
        cmd_ch.class_index <= it.cls;
        cmd_ch.from_state  <= it.from_st;
        cmd_ch.to_state    <= it.to_st;
        cmd_ch.last        <= it.last;
        tx_live = 1'b1;
        do @(posedge i_clk); while (cmd_ch.ready !== 1'b1);
        has_res = dfa_advance(it, st);
        if (has_res) final_state_q.push_back(use_typed ? typed_st : st);
        items_sent++;
    endtask

    // Drop valid and wait for every owed result; waits on the clock even when none is owed.
    task automatic drain_results();
        if (tx_live) cmd_ch.valid <= 1'b0;
        tx_live = 1'b0;
        do @(posedge i_clk); while (final_state_q.size() != 0);
    endtask

    // Config write; only called with the command path drained and settled.
    task automatic write_other_class(input logic [CLS_W-1:0] val);
        cfg_ch.valid       <= 1'b1;
        cfg_ch.other_class <= val;
        do @(posedge i_clk); while (cfg_ch.ready !== 1'b1);
        cfg_ch.valid <= 1'b0;
        other_cls = val;
    endtask

    // Directed rows, run with other_class at 63. Typed values: cleared store
    // gives 0, an unmapped byte follows class 63, and a space follows '|'.
    t_dir_row dir_table [0:DIR_ROWS-1] = '{
        '{'{CMD_TEXT,     8'h00, 6'd0,  8'd0,   8'd0,   1'b1}, 1'b1, 8'd0},
        '{'{CMD_WR_TRANS, 8'h00, 6'd63, 8'd0,   8'd255, 1'b0}, 1'b0, 8'd0},
        '{'{CMD_TEXT,     8'hFF, 6'd0,  8'd0,   8'd0,   1'b1}, 1'b1, 8'd255},
        '{'{CMD_WR_TRANS, 8'h00, 6'd63, 8'd255, 8'h5A,  1'b0}, 1'b0, 8'd0},
        '{'{CMD_TEXT,     8'h41, 6'd0,  8'd0,   8'd0,   1'b0}, 1'b0, 8'd0},
        '{'{CMD_TEXT,     8'h41, 6'd0,  8'd0,   8'd0,   1'b1}, 1'b0, 8'd0},
        '{'{CMD_RESTART,  8'hFF, 6'd63, 8'd255, 8'd255, 1'b1}, 1'b0, 8'd0},
        '{'{CMD_WR_CLASS, 8'h7C, 6'd0,  8'd0,   8'd0,   1'b1}, 1'b0, 8'd0},
        '{'{CMD_WR_TRANS, 8'h00, 6'd0,  8'd0,   8'd7,   1'b0}, 1'b0, 8'd0},
        '{'{CMD_TEXT,     8'h20, 6'd0,  8'd0,   8'd0,   1'b1}, 1'b1, 8'd7},
        '{'{CMD_WR_CLASS, 8'h20, 6'd5,  8'd0,   8'd0,   1'b0}, 1'b0, 8'd0},
        '{'{CMD_WR_TRANS, 8'h00, 6'd5,  8'd0,   8'd99,  1'b0}, 1'b0, 8'd0},
        '{'{CMD_RESTART,  8'h00, 6'd0,  8'd0,   8'd0,   1'b0}, 1'b0, 8'd0},
        '{'{CMD_TEXT,     8'h20, 6'd0,  8'd0,   8'd0,   1'b1}, 1'b1, 8'd7},
        '{'{CMD_WR_TRANS, 8'h00, 6'd0,  8'd7,   8'd255, 1'b1}, 1'b0, 8'd0},
        '{'{CMD_TEXT,     8'h7C, 6'd0,  8'd0,   8'd0,   1'b1}, 1'b0, 8'd0},
        '{'{CMD_WR_CLASS, 8'h5E, 6'd63, 8'd0,   8'd0,   1'b0}, 1'b0, 8'd0},
        '{'{CMD_TEXT,     8'h5E, 6'd0,  8'd0,   8'd0,   1'b1}, 1'b0, 8'd0},
        '{'{CMD_WR_CLASS, 8'hFF, 6'd63, 8'd0,   8'd0,   1'b0}, 1'b0, 8'd0},
        '{'{CMD_WR_TRANS, 8'h00, 6'd63, 8'h5A,  8'h80,  1'b0}, 1'b0, 8'd0},
        '{'{CMD_TEXT,     8'hFF, 6'd0,  8'd0,   8'd0,   1'b1}, 1'b0, 8'd0},
        '{'{CMD_RESTART,  8'h00, 6'd0,  8'd0,   8'd0,   1'b0}, 1'b0, 8'd0},
        '{'{CMD_TEXT,     8'h7C, 6'd0,  8'd0,   8'd0,   1'b0}, 1'b0, 8'd0},
        '{'{CMD_TEXT,     8'h00, 6'd0,  8'd0,   8'd0,   1'b1}, 1'b0, 8'd0}
    };

    // ------------------------------------------------------------------
    // Result side: random ready with bursts of stall, plus one long hold
    // ------------------------------------------------------------------
    initial begin
        res_ch.ready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_req) begin
                // long hold-off: the block fills its result slots and stalls input
                hold_req = 1'b0;
                res_ch.ready <= 1'b0;
                repeat (RX_HOLD_CYCLES) @(posedge i_clk);
            end else if (rx_idle_en && $urandom_range(0, 99) < 10) begin
                res_ch.ready <= 1'b0;
                repeat ($urandom_range(0, 10)) @(posedge i_clk);
            end else begin
                res_ch.ready <= 1'b1;
            end
        end
    end

    // Result checker: each accepted final state against the oldest expectation.
    always @(posedge i_clk) begin
        if (i_rst_n === 1'b1 && res_ch.valid === 1'b1 && res_ch.ready === 1'b1) begin
            if (final_state_q.size() == 0) begin
                $display("%0t: unexpected final_state, expected none, actual %0d",
                         $time, res_ch.final_state);
                mismatch_cnt++;
            end else if (res_ch.final_state !== final_state_q[0]) begin
                $display("%0t: final_state mismatch, expected %0d, actual %0d",
                         $time, final_state_q[0], res_ch.final_state);
                mismatch_cnt++;
                void'(final_state_q.pop_front());
            end else begin
                void'(final_state_q.pop_front());
            end
        end
    end

    // Run limit: set well above the reset sweep plus about 2k items at worst-case
    // gaps and stalls.
    initial begin
        #3_200_000;
        $display("testbench: done, errors");
        $finish;
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    initial begin
        int               ph, k, n, len, pick, start;
        logic [SYM_W-1:0] alpha [0:7];
        logic [ST_W-1:0]  wc_from, wc_to;
        logic [CLS_W-1:0] oc;

        // every input known from time zero
        cmd_ch.valid       = 1'b0;
        cmd_ch.command     = CMD_RESTART;
        cmd_ch.symbol_byte = '0;
        cmd_ch.class_index = '0;
        cmd_ch.from_state  = '0;
        cmd_ch.to_state    = '0;
        cmd_ch.last        = 1'b0;
        cfg_ch.valid       = 1'b0;
        cfg_ch.other_class = '0;
        i_rst_n            = 1'b0;

        // predictor reset: store cleared, all bytes unmapped
        for (k = 0; k < N_STATES * N_CLASSES; k++) trans_mem[k] = '0;
        for (k = 0; k < MAP_DEPTH; k++) begin
            map_vld[k] = 1'b0;
            map_cls[k] = '0;
        end
        dfa_state = '0;
        other_cls = OTHER_RESET;

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // other_class written right after reset, at its reset value;
        // the port takes it while the store sweep is still running
        write_other_class(6'd63);

        // directed part; the first item waits out the clearing sweep
        for (k = 0; k < DIR_ROWS; k++)
            send_cmd(dir_table[k].it, dir_table[k].chk, dir_table[k].want);

        // random phases, each at its own other_class; the last without idling
        for (ph = 0; ph < 4; ph++) begin
            drain_results();
            repeat (SETTLE_CYCLES) @(posedge i_clk);
            case (ph)
                0: oc = 6'd0;
                1: oc = CLS_W'($urandom_range(1, 62));
                2: oc = 6'd63;
                default: oc = CLS_W'($urandom());
            endcase
            write_other_class(oc);
            tx_idle_en = (ph != 3);
            rx_idle_en = (ph != 3);

            // small alphabet so text walks through loaded transitions
            alpha[0] = SPACE_BYTE;
            alpha[1] = BAR_BYTE;
            alpha[2] = CARET_BYTE;
            for (k = 3; k < 8; k++) alpha[k] = SYM_W'($urandom());

            start = items_sent;
            while (items_sent - start < PHASE_ITEMS) begin
                pick = $urandom_range(0, 99);
                if (ph == 1 && items_sent - start > PHASE_ITEMS / 2 && !hold_done) begin
                    // pressure: receiver holds off while we keep offering results
                    hold_done = 1'b1;
                    hold_req  = 1'b1;
                    for (k = 0; k < PRESSURE_ITEMS; k++)
                        send_cmd(mk_item(CMD_TEXT, alpha[$urandom_range(0, 7)], '0, '0, '0,
                                         1'b1));
                end else if (pick < 14) begin
                    // table load burst, mostly within a small state/class space
                    n = $urandom_range(2, 10);
                    for (k = 0; k < n; k++) begin
                        if ($urandom_range(0, 1))
                            send_cmd(mk_item(CMD_WR_CLASS, alpha[$urandom_range(0, 7)],
                                             ($urandom_range(0, 9) == 0) ? CLS_W'($urandom())
                                                 : CLS_W'($urandom_range(0, 3)),
                                             ST_W'($urandom()), ST_W'($urandom()),
                                             1'($urandom())));
                        else
                            send_cmd(mk_item(CMD_WR_TRANS, SYM_W'($urandom()),
                                             ($urandom_range(0, 9) == 0) ? other_cls
                                                 : CLS_W'($urandom_range(0, 3)),
                                             ($urandom_range(0, 9) == 0) ? ST_W'($urandom())
                                                 : ST_W'($urandom_range(0, 15)),
                                             ($urandom_range(0, 9) == 0) ? ST_W'($urandom())
                                                 : ST_W'($urandom_range(0, 15)),
                                             1'($urandom())));
                    end
                end else if (pick < 72) begin
                    // text run, optionally restarted, last on the final byte only
                    if ($urandom_range(0, 1))
                        send_cmd(mk_item(CMD_RESTART, SYM_W'($urandom()), CLS_W'($urandom()),
                                         ST_W'($urandom()), ST_W'($urandom()),
                                         1'($urandom())));
                    len = $urandom_range(1, 12);
                    for (k = 0; k < len; k++)
                        send_cmd(mk_item(CMD_TEXT,
                                         ($urandom_range(0, 99) < 85)
                                             ? alpha[$urandom_range(0, 7)] : SYM_W'($urandom()),
                                         CLS_W'($urandom()), ST_W'($urandom()),
                                         ST_W'($urandom()), k == len - 1));
                end else if (pick < 92) begin
                    // noise: every field fully random
                    n = $urandom_range(1, 4);
                    for (k = 0; k < n; k++)
                        send_cmd(mk_item(t_cmd'($urandom_range(0, 3)), SYM_W'($urandom()),
                                         CLS_W'($urandom()), ST_W'($urandom()),
                                         ST_W'($urandom()), 1'($urandom())));
                end else if (pick < 94) begin
                    // sender pauses until nothing is owed
                    drain_results();
                end else if (pick < 95) begin
                    // wildcard edge: same next state under every class
                    wc_from = ST_W'($urandom_range(0, 15));
                    wc_to   = ST_W'($urandom_range(0, 15));
                    for (k = 0; k < N_CLASSES; k++)
                        send_cmd(mk_item(CMD_WR_TRANS, '0, CLS_W'(k), wc_from, wc_to, 1'b0));
                end else begin
                    // broken run: bytes without last, then cut by a restart
                    len = $urandom_range(1, 5);
                    for (k = 0; k < len; k++)
                        send_cmd(mk_item(CMD_TEXT, alpha[$urandom_range(0, 7)], '0, '0, '0,
                                         1'b0));
                    send_cmd(mk_item(CMD_RESTART, '0, '0, '0, '0, 1'($urandom())));
                end
            end
        end

        drain_results();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (mismatch_cnt == 0) begin
            $display("testbench: done, clean");
        end else begin
            $display("testbench: done, errors");
        end
        $finish;
    end

endmodule
